FILE: sv/fixed_point_q24_8_alu_unit_macros.svh
// Assertion macros for the fixed-point ALU checker.
// Depends on clk_i and rst_ni being visible where the macros expand.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fixed point alu: check failed");

// Implication after a fixed number of clock edges.
`define FPA_ASSERT_LAT(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("fixed point alu: latency check failed");

`endif

FILE: sv/fpa_pkg.sv
// Shared types and constants of the fixed-point ALU.
// No dependencies.
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_e;

  // Work class: finished in the front, or needs the multiply or divide datapath.
  typedef enum logic [1:0] {
    CLS_SIMPLE,
    CLS_MUL,
    CLS_DIV
  } cls_e;

  typedef struct packed {
    cls_e cls;
    logic neg;   // sign of a product or quotient
    logic ovf;   // overflow already known (simple ops, divide by zero)
    logic cmp;   // comparison outcome
  } ctl_t;

  localparam int CtlBits    = $bits(ctl_t);
  localparam int QueueDepth = 4;

endpackage

FILE: sv/fpa_front.sv
// Front end of the fixed-point ALU: decodes the opcode, finishes all
// simple operations and prepares magnitudes for multiply and divide.
// Depends on fpa_pkg.
module fpa_front #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                        start,
  input  logic                        full_i,
  input  logic [3:0]                  func_i,
  input  logic signed [WORD_BITS-1:0] operand_a_i,
  input  logic signed [WORD_BITS-1:0] operand_b_i,
  output logic                        push_o,
  output fpa_pkg::ctl_t               ctl_o,
  output logic [WORD_BITS-1:0]        araw_o,
  output logic [WORD_BITS-1:0]        res_o,
  output logic [WORD_BITS-1:0]        amag_o,
  output logic [WORD_BITS-1:0]        bmag_o
);
  import fpa_pkg::*;

  localparam logic signed [WORD_BITS:0] One    = {{WORD_BITS{1'b0}}, 1'b1};
  localparam logic signed [WORD_BITS:0] MaxPos = {2'b00, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS:0] MaxNeg = -MaxPos;
  localparam logic [WORD_BITS-1:0] MaxRaw     = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] FromIntMax = MaxRaw >> FRAC_BITS;
  localparam logic [WORD_BITS-1:0] HalfLsb    = {{(WORD_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS-1);

  op_e                   op;
  logic [WORD_BITS-1:0]  a_u, b_u, amag, bmag, int_mag;
  logic signed [WORD_BITS:0] sa, sb, sum;
  logic                  ge, le, a_lt, a_gt;

  assign op   = op_e'(func_i);
  assign a_u  = operand_a_i;
  assign b_u  = operand_b_i;
  assign amag = a_u[WORD_BITS-1] ? (~a_u + 1'b1) : a_u;
  assign bmag = b_u[WORD_BITS-1] ? (~b_u + 1'b1) : b_u;
  assign sa   = {operand_a_i[WORD_BITS-1], operand_a_i};
  assign sb   = {operand_b_i[WORD_BITS-1], operand_b_i};
  assign a_lt = sa < sb;
  assign a_gt = sa > sb;
  assign ge   = (sa >= sb) || ((sa + One) == sb);
  assign le   = (sa <= sb) || ((sa - One) == sb);
  assign int_mag = (amag + HalfLsb) >> FRAC_BITS;

  assign push_o = start && !full_i;
  assign araw_o = a_u;
  assign amag_o = amag;
  assign bmag_o = bmag;

  always_comb begin
    ctl_o     = '0;
    ctl_o.cls = CLS_SIMPLE;
    ctl_o.neg = a_u[WORD_BITS-1] ^ b_u[WORD_BITS-1];
    res_o     = '0;
    sum       = sa + sb;
    unique case (op)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        unique case (op)
          OP_ADD:  sum = sa + sb;
          OP_SUB:  sum = sa - sb;
          OP_INC:  sum = sa + One;
          default: sum = sa - One;
        endcase
        ctl_o.ovf = (sum > MaxPos) || (sum < MaxNeg);
        res_o     = sum[WORD_BITS-1:0];
      end
      OP_MUL: ctl_o.cls = CLS_MUL;
      OP_DIV: begin
        ctl_o.cls = CLS_DIV;
        ctl_o.ovf = (bmag == '0);
      end
      OP_GT:  ctl_o.cmp = a_gt;
      OP_LT:  ctl_o.cmp = a_lt;
      OP_GE:  ctl_o.cmp = ge;
      OP_LE:  ctl_o.cmp = le;
      OP_EQ:  ctl_o.cmp = ge && le;
      OP_NE:  ctl_o.cmp = !(ge && le);
      OP_MIN: res_o = a_lt ? a_u : b_u;
      OP_MAX: res_o = a_gt ? a_u : b_u;
      OP_TOINT: res_o = a_u[WORD_BITS-1] ? (~int_mag + 1'b1) : int_mag;
      OP_FROMINT: begin
        ctl_o.ovf = amag > FromIntMax;
        res_o     = a_u << FRAC_BITS;
      end
      default: res_o = '0;
    endcase
    // overflow returns operand a unchanged
    if (ctl_o.ovf && (ctl_o.cls == CLS_SIMPLE)) begin
      res_o = a_u;
    end
  end

endmodule

FILE: sv/fpa_queue.sv
// Short queue between the ALU front end and the multiply/divide back end.
// Depends on fpa_pkg.
module fpa_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);
  import fpa_pkg::*;

  localparam int AW = $clog2(QueueDepth);

  logic [DATA_W-1:0] slot_q [QueueDepth];
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [AW:0]       cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == (AW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!push_i && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

endmodule

FILE: sv/fpa_back.sv
// Back end of the fixed-point ALU: a fixed-length pipeline that runs one restoring
// divide step per stage and a shift-add multiply step per multiplier bit, then rounds.
// Depends on fpa_pkg.
module fpa_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  fpa_pkg::ctl_t               ctl_i,
  input  logic [WORD_BITS-1:0]        araw_i,
  input  logic [WORD_BITS-1:0]        res_i,
  input  logic [WORD_BITS-1:0]        amag_i,
  input  logic [WORD_BITS-1:0]        bmag_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] result_value_o,
  output logic                        compare_true_o,
  output logic                        overflow_o
);
  import fpa_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int NW   = WORD_BITS + FRAC_BITS;
  localparam int NSTG = NW;
  localparam logic [2*W-1:0] HalfP = {{(2*W-1){1'b0}}, 1'b1} << (FRAC_BITS-1);

  logic            vld_q  [NSTG+1];
  ctl_t            ctl_q  [NSTG+1];
  logic [W-1:0]    araw_q [NSTG+1];
  logic [W-1:0]    res_q  [NSTG+1];
  logic [W-1:0]    a_q    [NSTG+1];
  logic [W-1:0]    b_q    [NSTG+1];
  logic [2*W-1:0]  acc_q  [NSTG+1];
  logic [NW-1:0]   num_q  [NSTG+1];
  logic [W-1:0]    rem_q  [NSTG+1];
  logic [NW-1:0]   quo_q  [NSTG+1];

  // load stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0]  <= ctl_i;
    araw_q[0] <= araw_i;
    res_q[0]  <= res_i;
    a_q[0]    <= amag_i;
    b_q[0]    <= bmag_i;
    acc_q[0]  <= '0;
    num_q[0]  <= {amag_i, {FRAC_BITS{1'b0}}};
    rem_q[0]  <= '0;
    quo_q[0]  <= '0;
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic [2*W-1:0] acc_n;
    logic [W:0]     rem_t, rem_s;
    logic           take;

    if (k < W) begin : g_mul
      // add the partial product for multiplier bit k
      assign acc_n = acc_q[k] + (b_q[k][k] ? ({{W{1'b0}}, a_q[k]} << k) : '0);
    end else begin : g_hold
      assign acc_n = acc_q[k];
    end

    assign rem_t = {rem_q[k], num_q[k][NW-1]};
    assign rem_s = rem_t - {1'b0, b_q[k]};
    assign take  = rem_t >= {1'b0, b_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else         vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      ctl_q[k+1]  <= ctl_q[k];
      araw_q[k+1] <= araw_q[k];
      res_q[k+1]  <= res_q[k];
      a_q[k+1]    <= a_q[k];
      b_q[k+1]    <= b_q[k];
      acc_q[k+1]  <= acc_n;
      num_q[k+1]  <= num_q[k] << 1;
      rem_q[k+1]  <= take ? rem_s[W-1:0] : rem_t[W-1:0];
      quo_q[k+1]  <= {quo_q[k][NW-2:0], take};
    end
  end

  // rounding, range check and sign
  logic [2*W-1:0] prod_r;
  logic [NW:0]    quo_r;
  logic           rnd_up, ovf_f;
  logic [W-1:0]   mag_f, res_f;
  ctl_t           ctl_f;

  assign ctl_f  = ctl_q[NSTG];
  assign prod_r = acc_q[NSTG] + HalfP;
  assign rnd_up = {rem_q[NSTG], 1'b0} >= {1'b0, b_q[NSTG]};
  assign quo_r  = {1'b0, quo_q[NSTG]} + {{NW{1'b0}}, rnd_up};

  always_comb begin
    ovf_f = ctl_f.ovf;
    mag_f = '0;
    res_f = res_q[NSTG];
    unique case (ctl_f.cls)
      CLS_MUL: begin
        ovf_f = |prod_r[2*W-1:W-1+FRAC_BITS];
        mag_f = prod_r[W-1+FRAC_BITS:FRAC_BITS];
        res_f = ctl_f.neg ? (~mag_f + 1'b1) : mag_f;
      end
      CLS_DIV: begin
        ovf_f = ctl_f.ovf || (|quo_r[NW:W-1]);
        mag_f = quo_r[W-1:0];
        res_f = ctl_f.neg ? (~mag_f + 1'b1) : mag_f;
      end
      default: res_f = res_q[NSTG];
    endcase
    if (ovf_f) res_f = araw_q[NSTG];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= vld_q[NSTG];
  end

  always_ff @(posedge clk_i) begin
    result_value_o <= res_f;
    compare_true_o <= ctl_f.cmp;
    overflow_o     <= ovf_f;
  end

endmodule

FILE: sv/fixed_point_q24_8_alu_unit.sv
// Top level of the signed fixed-point (Q24.8 by default) ALU.
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | start / busy         | func_i, operand_a_i, operand_b_i
//  result   | done_o (one cycle)   | result_value_o, compare_true_o, overflow_o
//
// One command is taken per clock while busy is low. Every command, simple or
// not, runs through the same multiply/divide pipeline of WORD_BITS+FRAC_BITS
// stages after the load stage, so results come back in order from the output
// register. Pipeline length is set by the divider, which retires one quotient
// bit per stage. Reset clears the queue and the valid flags only. The receiver
// cannot stall; busy rises only if the queue fills.
module fixed_point_q24_8_alu_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  func_i,
  input  logic signed [WORD_BITS-1:0] operand_a_i,
  input  logic signed [WORD_BITS-1:0] operand_b_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] result_value_o,
  output logic                        compare_true_o,
  output logic                        overflow_o
);
  import fpa_pkg::*;

  localparam int QW = CtlBits + 4*WORD_BITS;

  logic                 push, q_valid;
  ctl_t                 f_ctl, b_ctl;
  logic [WORD_BITS-1:0] f_araw, f_res, f_amag, f_bmag;
  logic [WORD_BITS-1:0] b_araw, b_res, b_amag, b_bmag;
  logic [QW-1:0]        q_out;

  // decode and finish the simple operations
  fpa_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .start       (start),
    .full_i      (busy),
    .func_i      (func_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .push_o      (push),
    .ctl_o       (f_ctl),
    .araw_o      (f_araw),
    .res_o       (f_res),
    .amag_o      (f_amag),
    .bmag_o      (f_bmag)
  );

  // decouple the front from the back; drain one entry every cycle while it holds one
  fpa_queue #(.DATA_W(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctl, f_araw, f_res, f_amag, f_bmag}),
    .pop_i   (q_valid),
    .full_o  (busy),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_ctl, b_araw, b_res, b_amag, b_bmag} = q_out;

  // multiply, divide, round and deliver
  fpa_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (q_valid),
    .ctl_i          (b_ctl),
    .araw_i         (b_araw),
    .res_i          (b_res),
    .amag_i         (b_amag),
    .bmag_i         (b_bmag),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .compare_true_o (compare_true_o),
    .overflow_o     (overflow_o)
  );

endmodule

FILE: sv/fpa_checker.sv
// Port-level checks of the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_q24_8_alu_unit_macros.svh.
`include "fixed_point_q24_8_alu_unit_macros.svh"

module fpa_checker #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [3:0]                  func_i,
  input logic signed [WORD_BITS-1:0] operand_b_i,
  input logic                        done_o,
  input logic signed [WORD_BITS-1:0] result_value_o,
  input logic                        compare_true_o,
  input logic                        overflow_o
);
  import fpa_pkg::*;

  localparam int Lat = WORD_BITS + FRAC_BITS + 3;

  logic mul_zero_xfer;

  assign mul_zero_xfer = start && !busy && (func_i == OP_MUL) && (operand_b_i == '0);

  // a result is either a compare outcome or an overflow, never both
  `FPA_ASSERT_NOW(a_ovf_no_cmp, done_o && overflow_o, !compare_true_o)

  // a true compare leaves the value field cleared
  `FPA_ASSERT_NOW(a_cmp_zero, done_o && compare_true_o, result_value_o == '0)

  // every transfer returns after the fixed pipeline latency
  `FPA_ASSERT_LAT(a_latency, start && !busy, Lat, done_o)

  // multiply by zero gives zero without overflow
  `FPA_ASSERT_LAT(a_mul_zero, mul_zero_xfer, Lat, done_o && (result_value_o == '0) && !overflow_o)

endmodule

bind fixed_point_q24_8_alu_unit fpa_checker #(
  .WORD_BITS(WORD_BITS),
  .FRAC_BITS(FRAC_BITS)
) u_fpa_checker (.*);

FILE: tb/sv/tb_fixed_point_q24_8_alu_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the signed Q24.8 fixed-point ALU.
// Depends on fpa_pkg and fixed_point_q24_8_alu_unit; needs no files or arguments.
module tb_fixed_point_q24_8_alu_unit;
  import fpa_pkg::*;

  localparam int  WordBits  = 32;
  localparam int  FracBits  = 8;
  localparam int  Latency   = WordBits + FracBits + 2;
  localparam logic signed [WordBits-1:0] MaxRaw = {1'b0, {(WordBits-1){1'b1}}};
  localparam int  CycleLimit = 200000;

  typedef struct {
    op_e                  op;
    logic [WordBits-1:0]  value;
    logic                 cmp;
    logic                 ovf;
  } alu_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [3:0]                  func_i;
  logic signed [WordBits-1:0]  operand_a_i;
  logic signed [WordBits-1:0]  operand_b_i;
  logic                        done_o;
  logic signed [WordBits-1:0]  result_value_o;
  logic                        compare_true_o;
  logic                        overflow_o;

  alu_result_t pending_results[$];
  int          mismatch_count;
  int          cycle_count;
  bit          gaps_enabled;

  fixed_point_q24_8_alu_unit #(
    .WORD_BITS(WordBits),
    .FRAC_BITS(FracBits)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .compare_true_o(compare_true_o),
    .overflow_o    (overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Exact ALU behavior on raw words, computed in 64-bit arithmetic.
  function automatic alu_result_t compute_alu(op_e op, logic signed [WordBits-1:0] a,
                                              logic signed [WordBits-1:0] b);
    alu_result_t r;
    longint sa, sb, ma, mb, wide, mag, quo, rem;
    bit neg, ge_tol, le_tol;
    sa = a;
    sb = b;
    ma = (sa < 0) ? -sa : sa;
    mb = (sb < 0) ? -sb : sb;
    neg = (sa < 0) != (sb < 0);
    ge_tol = (sa >= sb) || (sa + 1 == sb);
    le_tol = (sa <= sb) || (sa - 1 == sb);
    wide = 0;
    r.op = op;
    r.cmp = 1'b0;
    r.ovf = 1'b0;
    case (op)
      OP_ADD:  wide = sa + sb;
      OP_SUB:  wide = sa - sb;
      OP_INC:  wide = sa + 1;
      OP_DEC:  wide = sa - 1;
      OP_MUL: begin
        // Round the magnitude half away from zero, then apply the sign.
        mag = (ma * mb + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
        wide = neg ? -mag : mag;
      end
      OP_DIV: begin
        if (mb == 0) begin
          r.ovf = 1'b1;
        end else begin
          quo = (ma <<< FracBits) / mb;
          rem = (ma <<< FracBits) % mb;
          if (rem >= mb - rem) quo = quo + 1;
          wide = neg ? -quo : quo;
        end
      end
      OP_GT:   r.cmp = sa > sb;
      OP_LT:   r.cmp = sa < sb;
      OP_GE:   r.cmp = ge_tol;
      OP_LE:   r.cmp = le_tol;
      OP_EQ:   r.cmp = ge_tol && le_tol;
      OP_NE:   r.cmp = !(ge_tol && le_tol);
      OP_MIN:  wide = (sa < sb) ? sa : sb;
      OP_MAX:  wide = (sa > sb) ? sa : sb;
      OP_TOINT: begin
        mag = (ma + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
        wide = (sa < 0) ? -mag : mag;
      end
      default: begin
        r.ovf = ma > (MaxRaw >>> FracBits);
        wide = sa <<< FracBits;
      end
    endcase
    // Arithmetic results must land in the symmetric range.
    if (op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INC, OP_DEC}) begin
      if (wide > MaxRaw || wide < -MaxRaw) r.ovf = 1'b1;
    end
    r.value = r.ovf ? a : wide[WordBits-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WordBits-1:0] got,
                                 logic [WordBits-1:0] want);
    mismatch_count++;
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // Compare every result strobe against the oldest expectation.
  always @(negedge clk_i) begin
    alu_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result_value_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.value)
          report_mismatch({want.op.name(), " value"}, result_value_o, want.value);
        if (compare_true_o !== want.cmp)
          report_mismatch({want.op.name(), " compare"}, compare_true_o, want.cmp);
        if (overflow_o !== want.ovf)
          report_mismatch({want.op.name(), " overflow"}, overflow_o, want.ovf);
      end
    end
  end

  // Transfer one command; call at a rising edge, returns at the accepting edge.
  task automatic send_command(op_e op, logic signed [WordBits-1:0] a,
                              logic signed [WordBits-1:0] b);
    bit held;
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start       <= 1'b1;
    func_i      <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    // Sample busy mid-cycle so the accept decision never races the edge.
    do begin
      @(negedge clk_i);
      held = busy;
      @(posedge clk_i);
    end while (held);
    pending_results.push_back(compute_alu(op, a, b));
  endtask

  function automatic logic [WordBits-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4095) - 2048;
      1: return MaxRaw - $urandom_range(0, 3);
      2: return -MaxRaw + $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 1 << 24) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_arith_extremes();
    send_command(OP_ADD, MaxRaw, 1);
    send_command(OP_ADD, -MaxRaw, -1);
    send_command(OP_SUB, -MaxRaw, 1);
    send_command(OP_SUB, 5, -7);
    send_command(OP_MUL, 32'sh80, 1);
    send_command(OP_MUL, -32'sh80, 1);
    send_command(OP_MUL, 32'sh100000, 32'sh100000);
    send_command(OP_DIV, 32'sh300, 0);
    send_command(OP_DIV, 1, 2);
    send_command(OP_DIV, -32'sh100, 32'sh300);
    send_command(OP_DIV, MaxRaw, 1);
  endtask

  task automatic test_compare_tolerance();
    op_e op;
    for (int k = int'(OP_GT); k <= int'(OP_NE); k++) begin
      op = op_e'(k);
      send_command(op, 100, 101);
    end
    send_command(OP_EQ, 100, 102);
    send_command(OP_GE, 32'sh8000_0000, MaxRaw);
  endtask

  task automatic test_unary_edges();
    send_command(OP_MIN, 32'sh8000_0000, 3);
    send_command(OP_MAX, 32'sh8000_0000, 3);
    send_command(OP_INC, MaxRaw, 0);
    send_command(OP_DEC, -MaxRaw, 0);
    send_command(OP_TOINT, -32'sh80, 0);
    send_command(OP_TOINT, 32'sh8000_0000, 0);
    send_command(OP_FROMINT, 8388607, 0);
    send_command(OP_FROMINT, -8388608, 0);
  endtask

  // Random operations; neighbors of a often feed b to hit the one-LSB window.
  task automatic test_random_mix(int count);
    logic signed [WordBits-1:0] a, b;
    op_e op;
    for (int n = 0; n < count; n++) begin
      op = op_e'($urandom_range(0, 15));
      a  = pick_operand();
      b  = ($urandom_range(0, 3) == 0) ? a + $urandom_range(0, 4) - 2 : pick_operand();
      if (op == OP_FROMINT && $urandom_range(0, 1)) a = $urandom_range(0, 1 << 24) - (1 << 23);
      send_command(op, a, b);
    end
  endtask

  initial begin
    mismatch_count = 0;
    gaps_enabled   = 1'b1;
    rst_ni         = 1'b0;
    start          = 1'b0;
    func_i         = '0;
    operand_a_i    = '0;
    operand_b_i    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_arith_extremes();
    test_compare_tolerance();
    test_unary_edges();
    test_random_mix(380);
    // Run the tail back to back.
    gaps_enabled = 1'b0;
    test_random_mix(120);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
